[rtl/lowest_free_slot_table_core_defines.svh]
// Assertion helpers for the checker file of the slot table.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef LOWEST_FREE_SLOT_TABLE_CORE_DEFINES_SVH
`define LOWEST_FREE_SLOT_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LFST_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot table check failed");

// Next-cycle implication, disabled during reset.
`define LFST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot table check failed");

`endif

[rtl/lfst_pkg.sv]
`default_nettype none

package lfst_pkg;

  // Table geometry.
  localparam int SLOTS       = 64;
  localparam int BLOCK_SLOTS = 16;

  // Field widths.
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int SUM_W  = CNT_W + $clog2(BLOCK_SLOTS + 1);
  localparam int VAL_W  = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 3;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD        = 3'd0,
    CMD_ADD_UNIQUE = 3'd1,
    CMD_DEL_INDEX  = 3'd2,
    CMD_DEL_VALUE  = 3'd3,
    CMD_READ       = 3'd4,
    CMD_SWAP       = 3'd5,
    CMD_CONTAINS   = 3'd6,
    CMD_NEXT       = 3'd7
  } cmd_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_FULL       = 3'd1,
    STAT_NOT_FOUND  = 3'd2,
    STAT_DUPLICATE  = 3'd3,
    STAT_BAD_INDEX  = 3'd4,
    STAT_ZERO_VALUE = 3'd5
  } status_t;

  // Control of the slot store by the sequencer.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             wvalid;
    logic             clear;
    logic [IDX_W-1:0] raddr;
  } store_ctl_t;

endpackage

`default_nettype wire

[rtl/lfst_in_if.sv]
`default_nettype none

// Command channel of the slot table.
interface lfst_in_if;
  logic                       valid;
  logic                       ready;
  logic [lfst_pkg::CMD_W-1:0] command;
  logic [lfst_pkg::VAL_W-1:0] value;
  logic [lfst_pkg::IDX_W-1:0] index_a;
  logic [lfst_pkg::IDX_W-1:0] index_b;

  modport source (output valid, command, value, index_a, index_b, input ready);
  modport sink   (input valid, command, value, index_a, index_b, output ready);
endinterface

`default_nettype wire

[rtl/lfst_out_if.sv]
`default_nettype none

// Result channel of the slot table.
interface lfst_out_if;
  logic                        valid;
  logic                        ready;
  logic [lfst_pkg::STAT_W-1:0] status;
  logic [lfst_pkg::VAL_W-1:0]  result_value;
  logic [lfst_pkg::IDX_W-1:0]  result_index;
  logic [lfst_pkg::CNT_W-1:0]  occupied_count;
  logic [lfst_pkg::CNT_W-1:0]  extent;

  modport source (output valid, status, result_value, result_index, occupied_count, extent,
                  input ready);
  modport sink   (input valid, status, result_value, result_index, occupied_count, extent,
                  output ready);
endinterface

`default_nettype wire

[rtl/lfst_store.sv]
`default_nettype none

// Slot store: a one-write, one-read memory of values with a flip-flop
// occupied flag per slot. An unoccupied slot reads as empty whatever the
// memory holds, so reset and the clear on last delete act at once.
module lfst_store (
  input  wire                        clk,
  input  wire                        rst,
  input  wire lfst_pkg::store_ctl_t  ctl,
  input  wire [lfst_pkg::IDX_W-1:0]  probe_addr,
  output logic                       probe_valid,
  output logic [lfst_pkg::VAL_W-1:0] q_data,
  output logic                       q_valid
);
  import lfst_pkg::*;

  logic [VAL_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0] occ;

  // Occupied flags, looked up directly by the free-slot scan.
  assign probe_valid = occ[probe_addr];

  // Value memory with a registered read port.
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    q_data <= mem[ctl.raddr];
  end

  // Occupied flags and their registered copy for the read port.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ     <= '0;
      q_valid <= 1'b0;
    end else begin
      q_valid <= occ[ctl.raddr];
      if (ctl.clear) begin
        occ <= '0;
      end else if (ctl.we) begin
        occ[ctl.waddr] <= ctl.wvalid;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/lowest_free_slot_table_core.sv]
// A rejected command goes straight to the result stage; read and del_index read slot
// index_a, swap exchanges slots index_a and index_b, and add probes the occupied flags
// upward from slot 0. Contains, next_occupied and del_value search the extent, and
// add_unique searches it and then looks for a free slot. A stalled result holds the block
// until it leaves. One command at a time, ready again as the result is presented. Reset is
// synchronous; it clears the occupied flags at once, with no clearing pass.
`default_nettype none

module lowest_free_slot_table_core (
  input  wire        clk,
  input  wire        rst,
  lfst_in_if.sink    in_ch,
  lfst_out_if.source out_ch
);
  import lfst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FREE, S_SCAN, S_RDA, S_RDB, S_WRB, S_DEL, S_DONE
  } state_t;

  state_t           state;
  cmd_t             cmd_r;
  logic [VAL_W-1:0] val_r;
  logic [IDX_W-1:0] a_r;
  logic [IDX_W-1:0] b_r;
  logic [CNT_W-1:0] idx;
  logic             rd_live;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] extent;
  logic [VAL_W-1:0] qa;
  logic             qa_v;
  status_t          res_status;
  logic [VAL_W-1:0] res_value;
  logic [IDX_W-1:0] res_index;

  logic             out_valid;
  status_t          out_status;
  logic [VAL_W-1:0] out_value;
  logic [IDX_W-1:0] out_index;
  logic [CNT_W-1:0] out_count;
  logic [CNT_W-1:0] out_extent;

  store_ctl_t       ctl;
  logic             probe_valid;
  logic [VAL_W-1:0] q_data;
  logic             q_valid;

  cmd_t             in_cmd;
  logic             in_zero;
  logic             a_out;
  logic             b_out;
  logic             hit;
  logic             issue_ok;
  logic [SUM_W-1:0] ext_sum;
  logic [CNT_W-1:0] ext_grown;

  lfst_store u_store (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .probe_addr  (idx[IDX_W-1:0]),
    .probe_valid (probe_valid),
    .q_data      (q_data),
    .q_valid     (q_valid)
  );

  // Handshake and result ports.
  assign in_ch.ready           = (state == S_IDLE);
  assign out_ch.valid          = out_valid;
  assign out_ch.status         = out_status;
  assign out_ch.result_value   = out_value;
  assign out_ch.result_index   = out_index;
  assign out_ch.occupied_count = out_count;
  assign out_ch.extent         = out_extent;

  // Decode of the incoming command.
  assign in_cmd  = cmd_t'(in_ch.command);
  assign in_zero = (in_ch.value == '0);
  assign a_out   = (CNT_W'(in_ch.index_a) >= extent);
  assign b_out   = (CNT_W'(in_ch.index_b) >= extent);

  // Shared compare: the slot read last cycle against the search key, or any occupied slot for next_occupied.
  assign hit      = rd_live && q_valid && ((cmd_r == CMD_NEXT) || (q_data == val_r));
  assign issue_ok = (idx < extent);

  // Extent after a block is added, capped at the table size.
  assign ext_sum   = SUM_W'(extent) + SUM_W'(BLOCK_SLOTS);
  assign ext_grown = (ext_sum > SUM_W'(SLOTS)) ? CNT_W'(SLOTS) : ext_sum[CNT_W-1:0];

  // Store read address and write port, chosen by the sequencer state.
  always_comb begin
    ctl        = '0;
    ctl.raddr  = idx[IDX_W-1:0];
    ctl.waddr  = idx[IDX_W-1:0];
    ctl.wdata  = val_r;
    ctl.wvalid = 1'b1;
    case (state)
      S_IDLE: begin
        ctl.raddr = in_ch.index_a;
      end
      S_FREE: begin
        ctl.we = !probe_valid;
      end
      S_RDA: begin
        ctl.raddr = b_r;
      end
      S_RDB: begin
        ctl.raddr  = b_r;
        ctl.we     = 1'b1;
        ctl.waddr  = a_r;
        ctl.wdata  = q_data;
        ctl.wvalid = q_valid;
      end
      S_WRB: begin
        ctl.we     = 1'b1;
        ctl.waddr  = b_r;
        ctl.wdata  = qa;
        ctl.wvalid = qa_v;
      end
      S_DEL: begin
        ctl.we     = 1'b1;
        ctl.waddr  = res_index;
        ctl.wvalid = 1'b0;
        ctl.clear  = (count == CNT_W'(1));
      end
      default: begin
        ctl.raddr = idx[IDX_W-1:0];
      end
    endcase
  end

  // Sequencer, table counters and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      extent    <= '0;
      rd_live   <= 1'b0;
    end else begin
      // The result register empties once its transaction is taken, unless a new one loads.
      if (out_valid && out_ch.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        // Accept a transaction and screen out the cases that need no slot visit.
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r     <= in_cmd;
            val_r     <= in_ch.value;
            a_r       <= in_ch.index_a;
            b_r       <= in_ch.index_b;
            res_value <= '0;
            res_index <= '0;
            idx       <= (in_cmd == CMD_NEXT) ? CNT_W'(in_ch.index_a) : '0;
            rd_live   <= 1'b0;
            case (in_cmd)
              CMD_ADD: begin
                if (in_zero) begin
                  res_status <= STAT_ZERO_VALUE;
                  state      <= S_DONE;
                end else begin
                  res_status <= STAT_NOT_FOUND;
                  state      <= S_FREE;
                end
              end
              CMD_ADD_UNIQUE, CMD_DEL_VALUE, CMD_CONTAINS: begin
                if (in_zero) begin
                  res_status <= STAT_ZERO_VALUE;
                  state      <= S_DONE;
                end else begin
                  res_status <= STAT_NOT_FOUND;
                  state      <= S_SCAN;
                end
              end
              CMD_DEL_INDEX, CMD_READ: begin
                if (a_out) begin
                  res_status <= STAT_BAD_INDEX;
                  state      <= S_DONE;
                end else begin
                  res_status <= STAT_NOT_FOUND;
                  state      <= S_RDA;
                end
              end
              CMD_SWAP: begin
                if (a_out || b_out || (in_ch.index_a == in_ch.index_b)) begin
                  res_status <= STAT_BAD_INDEX;
                  state      <= S_DONE;
                end else begin
                  res_status <= STAT_NOT_FOUND;
                  state      <= S_RDA;
                end
              end
              CMD_NEXT: begin
                res_status <= STAT_NOT_FOUND;
                if (a_out) begin
                  state <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                res_status <= STAT_NOT_FOUND;
                state      <= S_DONE;
              end
            endcase
          end
        end

        // Lowest free slot: one occupied flag per cycle.
        S_FREE: begin
          if (!probe_valid) begin
            if (idx >= extent) begin
              extent <= ext_grown;
            end
            count      <= count + CNT_W'(1);
            res_status <= STAT_OK;
            res_value  <= val_r;
            res_index  <= idx[IDX_W-1:0];
            state      <= S_DONE;
          end else if (idx == CNT_W'(SLOTS - 1)) begin
            res_status <= STAT_FULL;
            state      <= S_DONE;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end

        // Search inside the extent: issue one read per cycle and compare the
        // slot read in the cycle before.
        S_SCAN: begin
          if (hit) begin
            res_value <= q_data;
            res_index <= rd_idx;
            case (cmd_r)
              CMD_ADD_UNIQUE: begin
                res_status <= STAT_DUPLICATE;
                state      <= S_DONE;
              end
              CMD_DEL_VALUE: begin
                res_status <= STAT_OK;
                state      <= S_DEL;
              end
              default: begin
                res_status <= STAT_OK;
                state      <= S_DONE;
              end
            endcase
          end else if (issue_ok) begin
            rd_live <= 1'b1;
            rd_idx  <= idx[IDX_W-1:0];
            idx     <= idx + CNT_W'(1);
          end else if (cmd_r == CMD_ADD_UNIQUE) begin
            idx     <= '0;
            rd_live <= 1'b0;
            state   <= S_FREE;
          end else begin
            state <= S_DONE;
          end
        end

        // Slot index_a has been read.
        S_RDA: begin
          if (cmd_r == CMD_SWAP) begin
            qa    <= q_data;
            qa_v  <= q_valid;
            state <= S_RDB;
          end else if (!q_valid) begin
            state <= S_DONE;
          end else begin
            res_status <= STAT_OK;
            res_value  <= q_data;
            res_index  <= a_r;
            state      <= (cmd_r == CMD_DEL_INDEX) ? S_DEL : S_DONE;
          end
        end

        // Swap: slot index_b lands in index_a during this cycle.
        S_RDB: begin
          state <= S_WRB;
        end

        // Swap: the saved index_a contents land in index_b.
        S_WRB: begin
          res_status <= STAT_OK;
          res_index  <= a_r;
          state      <= S_DONE;
        end

        // Delete the slot in res_index; the last delete empties the table.
        S_DEL: begin
          count <= count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            extent <= '0;
          end
          state <= S_DONE;
        end

        // Hand the result over once the output register is free.
        S_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_value  <= res_value;
            out_index  <= res_index;
            out_count  <= count;
            out_extent <= extent;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/lfst_checker.sv]
`default_nettype none
`include "lowest_free_slot_table_core_defines.svh"

// Port-level checks of the slot table.
module lfst_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire [lfst_pkg::CNT_W-1:0]  occupied_count,
  input wire [lfst_pkg::CNT_W-1:0]  extent
);
  import lfst_pkg::*;

  // A command in flight keeps the block from taking another.
  `LFST_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // A pending result is not withdrawn.
  `LFST_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid)

  // The extent is zero exactly when the table is empty.
  `LFST_ASSERT_IMPL(a_empty_extent, out_valid, (occupied_count == '0) == (extent == '0))

  // The occupied count stays within the extent, which never passes the table size.
  `LFST_ASSERT_IMPL(a_count_in_extent, out_valid,
                    (occupied_count <= extent) && (extent <= CNT_W'(SLOTS)))

endmodule

bind lowest_free_slot_table_core lfst_checker u_lfst_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .occupied_count (out_ch.occupied_count),
  .extent         (out_ch.extent)
);

`default_nettype wire
